@@ design/cle_pkg.sv @@
// ----------------------------------------------------------------------------
// cle_pkg: shared types and constants of the console line editor
// character codes, result kinds, controller states and the command and
// status groups that pass between the controller and the datapath
// ----------------------------------------------------------------------------
package cle_pkg;

   // default line store depth, one entry is always kept free
   localparam int LINE_BYTES_DEFAULT = 32;

   // character codes
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SP     = 8'h20;
   localparam logic [7:0] CH_DEL    = 8'h7F;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_U      = 8'h55;
   localparam logic [7:0] CH_C      = 8'h43;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CTRL_U    = 8'h15;
   localparam logic [7:0] CTRL_C    = 8'h03;

   typedef enum logic [1:0] {
      KIND_ECHO = 2'd0,
      KIND_LINE = 2'd1,
      KIND_END  = 2'd2,
      KIND_INTR = 2'd3
   } cle_kind_type;

   // class of the masked byte
   typedef enum logic [2:0] {
      CLS_PLAIN,
      CLS_BRACKET,
      CLS_LINE_END,
      CLS_ERASE,
      CLS_KILL,
      CLS_INTR
   } cle_class_type;

   // which result the datapath builds
   typedef enum logic [3:0] {
      OUT_BS,
      OUT_SP,
      OUT_CR,
      OUT_LF,
      OUT_CHAR,
      OUT_CARET,
      OUT_LETTER,
      OUT_INTR,
      OUT_LINE,
      OUT_END
   } cle_out_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ECHO_BS,
      ST_ECHO_SP,
      ST_ECHO_CR,
      ST_ECHO_CHAR,
      ST_CARET,
      ST_LETTER,
      ST_KILL_CR,
      ST_KILL_LF,
      ST_INTR,
      ST_FULL_BS1,
      ST_FULL_SP,
      ST_FULL_BS2,
      ST_LINE_RD,
      ST_LINE_OUT,
      ST_LINE_END
   } cle_state_type;

   typedef struct packed {
      logic            load_item;
      logic            cfg_write;
      logic            store_write;
      logic            wp_inc;
      logic            wp_dec;
      logic            wp_clear;
      logic            rd_start;
      logic            rd_next;
      logic            out_load;
      cle_out_sel_type out_sel;
      logic            out_last;
   } cle_cmd_type;

   typedef struct packed {
      logic          in_rub;
      logic          in_lf;
      cle_class_type cls;
      logic          full;
      logic          wp_zero;
      logic          rd_more;
      logic          abort_en;
      logic          out_free;
   } cle_status_type;

endpackage

@@ design/cle_datapath.sv @@
// ----------------------------------------------------------------------------
// cle_datapath: line store, write position and result register
// holds the current byte and its class, the line store memory with a
// registered read port, the abort flag and the outgoing result
// ----------------------------------------------------------------------------
module cle_datapath #(
   parameter int LINE_BYTES = cle_pkg::LINE_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cle_pkg::cle_cmd_type   cmd,
   output cle_pkg::cle_status_type status,
   input  logic [7:0]             req_raw_byte,
   input  logic                   csr_abort_enabled,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_kind,
   output logic [7:0]             rsp_data_byte,
   output logic [4:0]             rsp_line_length,
   output logic                   rsp_last
);

   localparam int PTR_W = $clog2(LINE_BYTES);

   logic [7:0]              byte_ff;
   cle_pkg::cle_class_type  cls_ff;
   logic [PTR_W-1:0]        wp_ff;
   logic [PTR_W-1:0]        wp_in;
   logic [PTR_W-1:0]        rd_idx_ff;
   logic [PTR_W-1:0]        rd_addr;
   logic [PTR_W:0]          rd_next_idx;
   logic                    rd_en;
   logic [6:0]              rd_data_ff;
   logic [6:0]              store_mem [LINE_BYTES];
   logic                    abort_ff;

   logic [7:0]              conv_byte;
   cle_pkg::cle_class_type  conv_cls;

   logic                    rsp_valid_ff;
   logic [1:0]              rsp_kind_ff;
   logic [1:0]              rsp_kind_in;
   logic [7:0]              rsp_data_ff;
   logic [7:0]              rsp_data_in;
   logic [4:0]              rsp_len_ff;
   logic [4:0]              rsp_len_in;
   logic                    rsp_last_ff;
   logic [31:0]             wp_wide;

   // cr becomes lf, del and bs become bs
   always_comb begin
      if (req_raw_byte == cle_pkg::CH_CR) begin
         conv_byte = cle_pkg::CH_LF;
      end else if (req_raw_byte == cle_pkg::CH_DEL || req_raw_byte == cle_pkg::CH_BS) begin
         conv_byte = cle_pkg::CH_BS;
      end else begin
         conv_byte = req_raw_byte;
      end
   end

   // classify on the low seven bits
   always_comb begin
      unique case (conv_byte[6:0])
         cle_pkg::CH_LBRACK[6:0], cle_pkg::CH_RBRACK[6:0]: conv_cls = cle_pkg::CLS_BRACKET;
         cle_pkg::CH_LF[6:0], cle_pkg::CH_CR[6:0]:         conv_cls = cle_pkg::CLS_LINE_END;
         cle_pkg::CH_BS[6:0]:                              conv_cls = cle_pkg::CLS_ERASE;
         cle_pkg::CTRL_U[6:0]:                             conv_cls = cle_pkg::CLS_KILL;
         cle_pkg::CTRL_C[6:0]:                             conv_cls = cle_pkg::CLS_INTR;
         default:                                          conv_cls = cle_pkg::CLS_PLAIN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         byte_ff <= conv_byte;
         cls_ff  <= conv_cls;
      end
   end

   // write position
   always_comb begin
      wp_in = wp_ff;
      if (cmd.wp_clear) begin
         wp_in = '0;
      end else if (cmd.wp_inc) begin
         wp_in = wp_ff + PTR_W'(1);
      end else if (cmd.wp_dec && wp_ff != '0) begin
         wp_in = wp_ff - PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         abort_ff <= 1'b0;
      end else begin
         wp_ff <= wp_in;
         if (cmd.cfg_write) begin
            abort_ff <= csr_abort_enabled;
         end
      end
   end

   // line store, one write and one registered read per cycle
   assign rd_next_idx = {1'b0, rd_idx_ff} + (PTR_W+1)'(1);
   assign rd_addr     = cmd.rd_start ? '0 : rd_next_idx[PTR_W-1:0];
   assign rd_en       = cmd.rd_start || cmd.rd_next;

   always_ff @(posedge clock) begin
      if (cmd.store_write) begin
         store_mem[wp_ff] <= byte_ff[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
         rd_idx_ff  <= rd_addr;
      end
   end

   // result mux
   always_comb begin
      wp_wide     = 32'(wp_ff);
      rsp_kind_in = cle_pkg::KIND_ECHO;
      rsp_data_in = '0;
      rsp_len_in  = '0;
      unique case (cmd.out_sel)
         cle_pkg::OUT_BS:    rsp_data_in = cle_pkg::CH_BS;
         cle_pkg::OUT_SP:    rsp_data_in = cle_pkg::CH_SP;
         cle_pkg::OUT_CR:    rsp_data_in = cle_pkg::CH_CR;
         cle_pkg::OUT_LF:    rsp_data_in = cle_pkg::CH_LF;
         cle_pkg::OUT_CHAR:  rsp_data_in = byte_ff;
         cle_pkg::OUT_CARET: rsp_data_in = cle_pkg::CH_CARET;
         cle_pkg::OUT_LETTER: begin
            rsp_data_in = (cls_ff == cle_pkg::CLS_KILL) ? cle_pkg::CH_U : cle_pkg::CH_C;
         end
         cle_pkg::OUT_INTR:  rsp_kind_in = cle_pkg::KIND_INTR;
         cle_pkg::OUT_LINE: begin
            rsp_kind_in = cle_pkg::KIND_LINE;
            rsp_data_in = {1'b0, rd_data_ff};
         end
         cle_pkg::OUT_END: begin
            rsp_kind_in = cle_pkg::KIND_END;
            rsp_len_in  = wp_wide[4:0];
         end
         default: rsp_data_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_data_ff <= rsp_data_in;
         rsp_len_ff  <= rsp_len_in;
         rsp_last_ff <= cmd.out_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_data_byte   = rsp_data_ff;
   assign rsp_line_length = rsp_len_ff;
   assign rsp_last        = rsp_last_ff;

   always_comb begin
      status.in_rub   = (req_raw_byte == cle_pkg::CH_DEL) || (req_raw_byte == cle_pkg::CH_BS);
      status.in_lf    = (conv_byte == cle_pkg::CH_LF);
      status.cls      = cls_ff;
      status.full     = (wp_ff == PTR_W'(LINE_BYTES - 1));
      status.wp_zero  = (wp_ff == '0);
      status.rd_more  = (rd_next_idx < {1'b0, wp_ff});
      status.abort_en = abort_ff;
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   // position never goes beyond the spare entry
   a_wp_bound: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= PTR_W'(LINE_BYTES - 1))
      else $error("write position beyond line store");

   // readout only touches written entries
   a_rd_written: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> rd_addr < wp_ff)
      else $error("line store read beyond write position");

   // no store write while the line is being read out
   a_no_rw_mix: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !cmd.store_write)
      else $error("store write during readout");

endmodule

@@ design/cle_controller.sv @@
// ----------------------------------------------------------------------------
// cle_controller: sequencer of the console line editor
// walks each byte through its echo, edit action and line readout, at most
// one result per step, and drives the datapath by command signals
// ----------------------------------------------------------------------------
module cle_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  cle_pkg::cle_status_type status,
   output cle_pkg::cle_cmd_type    cmd
);

   cle_pkg::cle_state_type state_ff;
   cle_pkg::cle_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cle_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = 1'b1;
      csr_ready = 1'b0;
      unique case (state_ff)
         cle_pkg::ST_IDLE: begin
            req_stall     = 1'b0;
            csr_ready     = 1'b1;
            cmd.cfg_write = csr_valid;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               if (status.in_rub) begin
                  state_in = cle_pkg::ST_ECHO_BS;
               end else if (status.in_lf) begin
                  state_in = cle_pkg::ST_ECHO_CR;
               end else begin
                  state_in = cle_pkg::ST_ECHO_CHAR;
               end
            end
         end
         cle_pkg::ST_ECHO_BS: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = cle_pkg::OUT_BS;
               state_in     = cle_pkg::ST_ECHO_SP;
            end
         end
         cle_pkg::ST_ECHO_SP: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = cle_pkg::OUT_SP;
               state_in     = cle_pkg::ST_ECHO_CHAR;
            end
         end
         cle_pkg::ST_ECHO_CR: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = cle_pkg::OUT_CR;
               state_in     = cle_pkg::ST_ECHO_CHAR;
            end
         end
         cle_pkg::ST_ECHO_CHAR: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = cle_pkg::OUT_CHAR;
               unique case (status.cls)
                  cle_pkg::CLS_BRACKET: begin
                     if (status.wp_zero) begin
                        // bracket opening a line ends it at once
                        cmd.store_write = 1'b1;
                        cmd.wp_inc      = 1'b1;
                        state_in        = cle_pkg::ST_LINE_RD;
                     end else if (status.full) begin
                        state_in = cle_pkg::ST_FULL_BS1;
                     end else begin
                        cmd.store_write = 1'b1;
                        cmd.wp_inc      = 1'b1;
                        state_in        = cle_pkg::ST_IDLE;
                     end
                  end
                  cle_pkg::CLS_LINE_END: begin
                     state_in = status.wp_zero ? cle_pkg::ST_LINE_END : cle_pkg::ST_LINE_RD;
                  end
                  cle_pkg::CLS_ERASE: begin
                     cmd.wp_dec = 1'b1;
                     state_in   = cle_pkg::ST_IDLE;
                  end
                  cle_pkg::CLS_KILL: begin
                     cmd.wp_clear = 1'b1;
                     state_in     = cle_pkg::ST_CARET;
                  end
                  cle_pkg::CLS_INTR: begin
                     state_in = cle_pkg::ST_CARET;
                  end
                  default: begin
                     if (status.full) begin
                        state_in = cle_pkg::ST_FULL_BS1;
                     end else begin
                        cmd.store_write = 1'b1;
                        cmd.wp_inc      = 1'b1;
                        state_in        = cle_pkg::ST_IDLE;
                     end
                  end
               endcase
            end
         end
         cle_pkg::ST_CARET: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = cle_pkg::OUT_CARET;
               state_in     = cle_pkg::ST_LETTER;
            end
         end
         cle_pkg::ST_LETTER: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = cle_pkg::OUT_LETTER;
               state_in     = (status.cls == cle_pkg::CLS_KILL) ? cle_pkg::ST_KILL_CR
                                                                : cle_pkg::ST_INTR;
            end
         end
         cle_pkg::ST_KILL_CR: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = cle_pkg::OUT_CR;
               state_in     = cle_pkg::ST_KILL_LF;
            end
         end
         cle_pkg::ST_KILL_LF: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = cle_pkg::OUT_LF;
               state_in     = cle_pkg::ST_IDLE;
            end
         end
         cle_pkg::ST_INTR: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = cle_pkg::OUT_INTR;
               if (status.abort_en) begin
                  cmd.wp_clear = 1'b1;
                  state_in     = cle_pkg::ST_IDLE;
               end else if (status.full) begin
                  state_in = cle_pkg::ST_FULL_BS1;
               end else begin
                  cmd.store_write = 1'b1;
                  cmd.wp_inc      = 1'b1;
                  state_in        = cle_pkg::ST_IDLE;
               end
            end
         end
         cle_pkg::ST_FULL_BS1: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = cle_pkg::OUT_BS;
               state_in     = cle_pkg::ST_FULL_SP;
            end
         end
         cle_pkg::ST_FULL_SP: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = cle_pkg::OUT_SP;
               state_in     = cle_pkg::ST_FULL_BS2;
            end
         end
         cle_pkg::ST_FULL_BS2: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = cle_pkg::OUT_BS;
               state_in     = cle_pkg::ST_IDLE;
            end
         end
         cle_pkg::ST_LINE_RD: begin
            cmd.rd_start = 1'b1;
            state_in     = cle_pkg::ST_LINE_OUT;
         end
         cle_pkg::ST_LINE_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = cle_pkg::OUT_LINE;
               if (status.rd_more) begin
                  cmd.rd_next = 1'b1;
               end else begin
                  state_in = cle_pkg::ST_LINE_END;
               end
            end
         end
         cle_pkg::ST_LINE_END: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = cle_pkg::OUT_END;
               cmd.wp_clear = 1'b1;
               state_in     = cle_pkg::ST_IDLE;
            end
         end
         default: state_in = cle_pkg::ST_IDLE;
      endcase
      cmd.out_last = (state_in == cle_pkg::ST_IDLE);
   end

   // the final result of a byte hands control back to idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && cmd.out_last |=> state_ff == cle_pkg::ST_IDLE)
      else $error("last result not followed by idle");

   // a byte is only taken in idle, and an accepted byte always leaves idle
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_item |=> state_ff != cle_pkg::ST_IDLE)
      else $error("accepted byte produced no work");

endmodule

@@ design/console_line_editor.sv @@
// ----------------------------------------------------------------------------
// console_line_editor: canonical line editing of raw console bytes
// echoes each keyboard byte, edits a line store and reads a completed
// line out, followed by a line end marker; ctrl-c gives an interrupt marker
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+----------------------------------
//   req     | in        | req_valid/stall   | req_raw_byte
//   rsp     | out       | rsp_valid/stall   | rsp_kind, rsp_data_byte,
//           |           |                   | rsp_line_length, rsp_last
//   csr     | in        | csr_valid/ready   | csr_abort_enabled
//
// an ordinary byte is accepted in idle and then echoed; each further result
// adds one more state; a line end with stored bytes starts the registered
// line store read, then loads each stored byte and finally the marker
// the sequencer handles one transaction at a time; req_stall is high from
// accept until the final result is loaded into the result register
// a result waiting on rsp_stall holds the sequencer only when the next
// result is due; synchronous reset clears position, abort flag and state
// ----------------------------------------------------------------------------
module console_line_editor #(
   parameter int LINE_BYTES = cle_pkg::LINE_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // input bytes
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_raw_byte,
   // results
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [4:0] rsp_line_length,
   output logic       rsp_last,
   // abort control register
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_abort_enabled
);

   // command and status between sequencer and datapath
   cle_pkg::cle_cmd_type    cmd;
   cle_pkg::cle_status_type status;

   // sequencer: echo steps, edit action, line readout
   cle_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // line store, write position, abort flag and result register
   cle_datapath #(
      .LINE_BYTES (LINE_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_raw_byte      (req_raw_byte),
      .csr_abort_enabled (csr_abort_enabled),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_line_length   (rsp_line_length),
      .rsp_last          (rsp_last)
   );

endmodule
